@@ hdl/hostname_blocklist_matcher_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the hostname blocklist matcher
// Clocked concurrent assertions with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef HOSTNAME_BLOCKLIST_MATCHER_ASSERT_SVH
`define HOSTNAME_BLOCKLIST_MATCHER_ASSERT_SVH

// Property checked at every rising edge, off while reset is low
`define HBM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, off while reset is low
`define HBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ hdl/hbm_pkg.sv @@
// ----------------------------------------------------------------------------
// hbm_pkg
// Sizes, input codes and the transaction token for the blocklist matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hbm_pkg;

	// table geometry
	localparam int MAX_ENTRIES = 128;
	localparam int ENTRY_BYTES = 128;

	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int ADDR_W = $clog2(ENTRY_BYTES);
	localparam int LEN_W  = ADDR_W;
	localparam int POS_W  = 16;

	localparam int PREFIX_LEN = 4;
	localparam logic [POS_W-1:0] QPOS_MAX = '1;

	// cycles from an accepted query byte to its result strobe
	localparam int LATENCY = 2 * MAX_ENTRIES + 1;

	localparam logic [7:0] CHAR_W   = 8'h77;
	localparam logic [7:0] CHAR_DOT = 8'h2E;

	// input mode codes
	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	// token passed from cell to cell
	typedef struct packed {
		logic             vld;
		logic             is_query;
		logic [7:0]       c;
		logic             last;
		logic [POS_W-1:0] pos;    // load position or host position
		logic [IDX_W-1:0] idx;    // entry under load
		logic [CNT_W-1:0] total;  // entries stored when issued
		logic             wr;     // load byte is stored
		logic             close;  // load closes the entry
		logic             qact;   // a host was part way streamed
		logic             hit;    // running match result
	} token_t;

	// byte k of "www."
	function automatic logic [7:0] www_byte(input logic [1:0] k);
		logic [7:0] b;
		b = (k == 2'd3) ? CHAR_DOT : CHAR_W;
		return b;
	endfunction

endpackage

`default_nettype wire

@@ hdl/hostname_blocklist_matcher.sv @@
// A result strobes when the token of its final query byte leaves the last cell of the row.
// Throughput: one transaction per cycle while busy is low; the entry cells are pipelined.
// The token walks the row of entry cells, through tok_s1 then tok_q of each, gathering the hit.
// Reset: table empty, positions zero; busy is high during reset and clears at the next clock.
// The receiver cannot stall: done is a single-cycle strobe.
// ----------------------------------------------------------------------------
// hostname_blocklist_matcher
// Exact host name blocklist with "www." folding, built as a chain of cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hostname_blocklist_matcher import hbm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] char_code,
	input  wire logic       end_of_name,
	output logic            done,
	output logic            blocked,
	output logic [7:0]      entries_held
);

	logic             busy_q;
	logic [CNT_W-1:0] total_q;
	logic [LEN_W-1:0] ldpos_q;
	logic [POS_W-1:0] qpos_q;
	token_t           tok_h;
	token_t           tok_d;
	logic             accept;
	logic             room;
	logic             wr;

	assign accept = start && !busy_q;
	assign room   = total_q < CNT_W'(MAX_ENTRIES);
	assign wr     = room && (ldpos_q < LEN_W'(ENTRY_BYTES - 1));

	// token built from the accepted transaction
	always_comb begin
		tok_d       = '0;
		tok_d.c     = char_code;
		tok_d.last  = end_of_name;
		tok_d.total = total_q;
		tok_d.idx   = IDX_W'(total_q);
		tok_d.qact  = qpos_q != '0;
		if (accept) begin
			unique case (mode)
				MODE_LOAD: begin
					tok_d.vld   = 1'b1;
					tok_d.pos   = POS_W'(ldpos_q);
					tok_d.wr    = wr;
					tok_d.close = room && end_of_name;
				end
				MODE_QUERY: begin
					tok_d.vld      = 1'b1;
					tok_d.is_query = 1'b1;
					tok_d.pos      = qpos_q;
				end
				default: begin
				end
			endcase
		end
	end

	// head: positions, entry count and token issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			total_q <= '0;
			ldpos_q <= '0;
			qpos_q  <= '0;
			tok_h   <= '0;
		end else begin
			busy_q <= 1'b0;
			tok_h  <= tok_d;
			if (accept) begin
				unique case (mode)
					MODE_CLEAR: begin
						total_q <= '0;
						ldpos_q <= '0;
						qpos_q  <= '0;
					end
					MODE_LOAD: begin
						if (end_of_name) begin
							ldpos_q <= '0;
						end else if (wr) begin
							ldpos_q <= ldpos_q + LEN_W'(1);
						end
						if (room && end_of_name) begin
							total_q <= total_q + CNT_W'(1);
						end
					end
					MODE_QUERY: begin
						if (end_of_name) begin
							qpos_q <= '0;
						end else if (qpos_q != QPOS_MAX) begin
							qpos_q <= qpos_q + POS_W'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// row of entry cells
	token_t chain [MAX_ENTRIES+1];
	assign chain[0] = tok_h;

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		hbm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(g)),
			.tok_in   (chain[g]),
			.tok_out  (chain[g+1])
		);
	end

	// result at the end of the row
	assign busy         = busy_q;
	assign done         = chain[MAX_ENTRIES].vld && chain[MAX_ENTRIES].is_query
	                      && chain[MAX_ENTRIES].last;
	assign blocked      = chain[MAX_ENTRIES].hit;
	assign entries_held = 8'(chain[MAX_ENTRIES].total);

endmodule

`default_nettype wire

@@ hdl/hbm_ram.sv @@
// ----------------------------------------------------------------------------
// hbm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, or read into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

@@ hdl/hbm_cell.sv @@
// ----------------------------------------------------------------------------
// hbm_cell
// One table entry: its bytes, length and three running match flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbm_cell import hbm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] cell_idx,
	input  wire token_t           tok_in,
	output token_t                tok_out
);

	token_t            tok_s1;
	token_t            tok_q;
	logic [7:0]        rdata;
	logic [2:0]        flags_q;
	logic [LEN_W-1:0]  len_q;
	logic [7:0]        first_q [PREFIX_LEN];
	logic [7:0]        hist_q  [8];

	logic              mine_in;
	logic              we;
	logic [ADDR_W-1:0] addr;

	// entry bytes; a query reads four ahead of the host position
	assign mine_in = tok_in.idx == cell_idx;
	assign we      = tok_in.vld && !tok_in.is_query && tok_in.wr && mine_in;
	assign addr    = tok_in.is_query ? ADDR_W'(tok_in.pos + POS_W'(PREFIX_LEN))
	                                 : tok_in.pos[ADDR_W-1:0];

	hbm_ram #(.WIDTH(8), .DEPTH(ENTRY_BYTES)) u_ram (
		.clk   (clk),
		.we    (we),
		.addr  (addr),
		.wdata (tok_in.c),
		.rdata (rdata)
	);

	// compare stage
	logic              mine_s1;
	logic              active;
	logic [POS_W:0]    p17;
	logic [POS_W:0]    el17;
	logic [POS_W:0]    hl;
	logic [7:0]        nm_p;
	logic [7:0]        nm_pm4;
	logic              pref;
	logic              e0, e1, e2;
	logic [2:0]        f_cur;
	logic [2:0]        f_nxt;
	logic              hitc;
	logic              q_upd;
	token_t            tok_nxt;

	always_comb begin
		mine_s1 = tok_s1.idx == cell_idx;
		active  = CNT_W'(cell_idx) < tok_s1.total;
		p17     = {1'b0, tok_s1.pos};
		el17    = (POS_W+1)'(len_q);
		hl      = p17 + (POS_W+1)'(1);
		// hist_q[3] holds byte p, hist_q[7] byte p-4 once far enough in
		nm_p    = (tok_s1.pos < POS_W'(4)) ? first_q[tok_s1.pos[1:0]] : hist_q[3];
		nm_pm4  = (tok_s1.pos < POS_W'(8)) ? first_q[tok_s1.pos[1:0]] : hist_q[7];
		pref    = (len_q >= LEN_W'(PREFIX_LEN)) && (first_q[0] == www_byte(2'd0))
		          && (first_q[1] == www_byte(2'd1)) && (first_q[2] == www_byte(2'd2))
		          && (first_q[3] == www_byte(2'd3));
		e0      = (p17 < el17) && (nm_p == tok_s1.c);
		if (tok_s1.pos < POS_W'(PREFIX_LEN)) begin
			e1 = tok_s1.c == www_byte(tok_s1.pos[1:0]);
		end else begin
			e1 = (p17 - (POS_W+1)'(PREFIX_LEN) < el17) && (nm_pm4 == tok_s1.c);
		end
		e2      = pref && (p17 + (POS_W+1)'(PREFIX_LEN) < el17) && (rdata == tok_s1.c);
		f_cur   = (tok_s1.pos == '0) ? 3'b111 : flags_q;
		f_nxt   = f_cur & {e2, e1, e0};
		hitc    = (f_nxt[0] && (el17 == hl))
		          || (f_nxt[1] && (hl >= (POS_W+1)'(PREFIX_LEN))
		              && (hl - (POS_W+1)'(PREFIX_LEN) == el17))
		          || (f_nxt[2] && (el17 >= (POS_W+1)'(PREFIX_LEN))
		              && (el17 - (POS_W+1)'(PREFIX_LEN) == hl));
		q_upd   = tok_s1.vld && tok_s1.is_query && active;
		tok_nxt     = tok_s1;
		tok_nxt.hit = tok_s1.hit || (q_upd && tok_s1.last && hitc);
	end

	// token registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1  <= '0;
			tok_q   <= '0;
			flags_q <= 3'b111;
		end else begin
			tok_s1 <= tok_in;
			tok_q  <= tok_nxt;
			if (q_upd) begin
				flags_q <= f_nxt;
			end else if (tok_s1.vld && !tok_s1.is_query && mine_s1 && tok_s1.close
			             && tok_s1.qact) begin
				flags_q <= 3'b000;
			end
		end
	end

	// entry length, leading bytes and read history
	always_ff @(posedge clk) begin
		if (tok_s1.vld && !tok_s1.is_query && mine_s1) begin
			if (tok_s1.wr && (tok_s1.pos < POS_W'(PREFIX_LEN))) begin
				first_q[tok_s1.pos[1:0]] <= tok_s1.c;
			end
			if (tok_s1.close) begin
				len_q <= tok_s1.pos[LEN_W-1:0] + LEN_W'(tok_s1.wr);
			end
		end
		if (tok_s1.vld && tok_s1.is_query) begin
			hist_q[0] <= rdata;
			for (int k = 1; k < 8; k++) begin
				hist_q[k] <= hist_q[k-1];
			end
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

@@ hdl/hbm_checker.sv @@
// ----------------------------------------------------------------------------
// hbm_checker
// Port-level checks on the blocklist matcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hostname_blocklist_matcher_assert.svh"

module hbm_checker import hbm_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [1:0] mode,
	input wire logic [7:0] char_code,
	input wire logic       end_of_name,
	input wire logic       done,
	input wire logic       blocked,
	input wire logic [7:0] entries_held
);

	logic q_last;
	assign q_last = start && !busy && (mode == MODE_QUERY) && end_of_name;

	// busy only around reset
	`HBM_ASSERT(a_no_busy, clk, arst_n, !($past(arst_n) && busy), "busy after reset")

	// every result comes from a final query byte a fixed latency earlier
	`HBM_ASSERT_IMP(a_done_src, clk, arst_n, done, $past(q_last, LATENCY), "stray result")

	// every final query byte yields a result
	`HBM_ASSERT_IMP(a_done_lat, clk, arst_n, q_last, ##LATENCY done, "result lost")

	// at each result, the count never exceeds the table size
	`HBM_ASSERT_IMP(a_count, clk, arst_n, done, 32'(entries_held) <= MAX_ENTRIES, "bad count")

endmodule

bind hostname_blocklist_matcher hbm_checker u_hbm_checker (.*);

`default_nettype wire
